// ===== hdl/double_ended_queue_assert.svh =====
// assertion macros for the deque datapath rtl
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/deq_pkg.sv =====
package deq_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // fixed field widths of the beats
  localparam int FUNC_W   = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic [COUNT_W-1:0]      element_count;
    logic                    is_empty;
  } out_item_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic read;
    logic load;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } deq_stat_t;

  // ring index step forward
  function automatic idx_t idx_inc(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // ring index step back
  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

  // stored word to output field, sign extended or cut
  function automatic logic signed [VAL_W-1:0] widen(input data_t d);
    return VAL_W'($signed(d));
  endfunction

endpackage

// ===== hdl/deq_ctrl.sv =====
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_stat_t stat,
  output deq_pkg::deq_cmd_t  cmd
);
  import deq_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/deq_dp.sv =====
`include "double_ended_queue_assert.svh"

module deq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::in_item_t  in_data,
  input  deq_pkg::deq_cmd_t  cmd,
  output deq_pkg::deq_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data
);
  import deq_pkg::*;

  data_t     mem [DEPTH];
  idx_t      front_r, front_nxt;
  idx_t      rear_r, rear_nxt;
  cnt_t      count_r, count_nxt;
  status_t   status_r, status_nxt;
  data_t     rd_front_r, rd_rear_r;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      wr_en;
  idx_t      wr_addr;
  logic      full, empty;
  logic [CNT_W:0] tail_sum;
  idx_t      tail_idx;

  assign full  = (count_r == cnt_t'(DEPTH));
  assign empty = (count_r == '0);

  // operation decode: index moves, count and write strobe
  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    wr_en      = 1'b0;
    wr_addr    = rear_r;
    case (in_data.func)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status_nxt = STATUS_OVERFLOW;
        end else begin
          front_nxt = idx_dec(front_r);
          wr_en     = 1'b1;
          wr_addr   = idx_dec(front_r);
          count_nxt = cnt_t'(count_r + 1'b1);
        end
      end
      FUNC_PUSH_REAR: begin
        if (full) begin
          status_nxt = STATUS_OVERFLOW;
        end else begin
          rear_nxt  = idx_inc(rear_r);
          wr_en     = 1'b1;
          wr_addr   = rear_r;
          count_nxt = cnt_t'(count_r + 1'b1);
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_nxt = STATUS_UNDERFLOW;
        end else begin
          front_nxt = idx_inc(front_r);
          count_nxt = cnt_t'(count_r - 1'b1);
        end
      end
      FUNC_POP_REAR: begin
        if (empty) begin
          status_nxt = STATUS_UNDERFLOW;
        end else begin
          rear_nxt  = idx_dec(rear_r);
          count_nxt = cnt_t'(count_r - 1'b1);
        end
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      rear_r      <= '0;
      count_r     <= '0;
      status_r    <= STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        front_r  <= front_nxt;
        rear_r   <= rear_nxt;
        count_r  <= count_nxt;
        status_r <= status_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // ring storage, one write and two registered reads
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= DATA_WIDTH'(in_data.value);
    end
    if (cmd.read) begin
      rd_front_r <= mem[front_r];
      rd_rear_r  <= mem[idx_dec(rear_r)];
    end
  end

  // result beat assembly
  always_comb begin
    out_nxt.status        = status_r;
    out_nxt.element_count = COUNT_W'(count_r);
    out_nxt.is_empty      = empty;
    out_nxt.front_value   = empty ? '0 : widen(rd_front_r);
    out_nxt.rear_value    = empty ? '0 : widen(rd_rear_r);
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= out_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  // rear slot expected from front and count
  assign tail_sum = (CNT_W+1)'(front_r) + (CNT_W+1)'(count_r);
  assign tail_idx = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
                    idx_t'(tail_sum - (CNT_W+1)'(DEPTH)) : idx_t'(tail_sum);

  `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= cnt_t'(DEPTH), "fill count beyond depth")
  `DEQ_ASSERT_NOW(a_ring_consistent, 1'b1, tail_idx == rear_r, "rear index out of step with front and count")
  `DEQ_ASSERT_NEXT(a_overflow_frozen, cmd.exec && full && (in_data.func == FUNC_PUSH_FRONT || in_data.func == FUNC_PUSH_REAR), status_r == STATUS_OVERFLOW && $stable(count_r) && $stable(front_r) && $stable(rear_r), "overflow push changed state")
  `DEQ_ASSERT_NEXT(a_load_shows, cmd.load, out_valid_r && out_r.element_count == COUNT_W'(count_r), "loaded beat missing or stale count")

endmodule

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue of signed values in a ring buffer. Each input
// beat carries one operation (push front, push rear, pop front, pop rear or
// query) and yields exactly one result beat with a status, the front and rear
// values, the element count and an empty flag, all taken after the operation.
// Pop on empty reports underflow and push on full reports overflow; neither
// changes the contents. An item goes through these steps in order: the
// accept edge applies the operation and writes the ring, then front and
// rear are read from the two read ports of the storage array, and then the
// output register is loaded. The input is accepted again right after, even
// while the previous result waits in the output register; a result that is
// not taken holds the next one in the load step.
module double_ended_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_item_t out_data
);
  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  // sequencer
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring storage, indices and output register
  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/double_ended_queue_tb.sv =====
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int RANDOM_OPS = 700;
  localparam int PAUSE_AT   = 200;
  localparam int QUIET_FROM = 350;
  localparam int QUIET_TO   = 500;
  localparam int IDLE_PCT   = 7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // operations waiting to be driven, deque views waiting to come back
  in_item_t    op_backlog[$];
  out_item_t   expected_views[$];
  int unsigned accepted_ops = 0;
  int          mismatches = 0;

  // mirror of the ring buffer
  data_t mirror_ring[DEPTH];
  int    mirror_head = 0;
  int    mirror_tail = 0;
  int    mirror_fill = 0;

  double_ended_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // apply one operation to the mirror and return the view after it
  function automatic out_item_t deque_apply(input in_item_t op);
    out_item_t view;
    view = '0;
    view.status = STATUS_OK;
    case (op.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_REAR: begin
        if (mirror_fill >= DEPTH) begin
          view.status = STATUS_OVERFLOW;
        end else if (op.func == FUNC_PUSH_FRONT) begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_ring[mirror_head] = data_t'(op.value);
          mirror_fill++;
        end else begin
          mirror_ring[mirror_tail] = data_t'(op.value);
          mirror_tail = (mirror_tail + 1) % DEPTH;
          mirror_fill++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_REAR: begin
        if (mirror_fill == 0) begin
          view.status = STATUS_UNDERFLOW;
        end else if (op.func == FUNC_POP_FRONT) begin
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_fill--;
        end else begin
          mirror_tail = (mirror_tail + DEPTH - 1) % DEPTH;
          mirror_fill--;
        end
      end
      default: ;
    endcase
    if (mirror_fill != 0) begin
      view.front_value = VAL_W'($signed(mirror_ring[mirror_head]));
      view.rear_value  = VAL_W'($signed(mirror_ring[(mirror_tail + DEPTH - 1) % DEPTH]));
    end
    view.element_count = COUNT_W'(mirror_fill);
    view.is_empty      = (mirror_fill == 0);
    return view;
  endfunction

  // field by field comparison of one result beat
  task automatic compare_view(input out_item_t exp_v, input out_item_t got);
    if (got.status !== exp_v.status) begin
      $error("status expected %0d actual %0d", exp_v.status, got.status);
      mismatches++;
    end
    if (got.front_value !== exp_v.front_value) begin
      $error("front_value expected %0d actual %0d", exp_v.front_value, got.front_value);
      mismatches++;
    end
    if (got.rear_value !== exp_v.rear_value) begin
      $error("rear_value expected %0d actual %0d", exp_v.rear_value, got.rear_value);
      mismatches++;
    end
    if (got.element_count !== exp_v.element_count) begin
      $error("element_count expected %0d actual %0d", exp_v.element_count,
             got.element_count);
      mismatches++;
    end
    if (got.is_empty !== exp_v.is_empty) begin
      $error("is_empty expected %0d actual %0d", exp_v.is_empty, got.is_empty);
      mismatches++;
    end
  endtask

  function automatic void queue_op(input logic [FUNC_W-1:0] f, input logic [VAL_W-1:0] v);
    in_item_t op;
    op.func  = f;
    op.value = v;
    op_backlog.push_back(op);
  endfunction

  // mostly full-range words, sometimes an extreme
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // input driver: one beat at a time from the backlog
  always @(posedge clk) begin
    int unsigned taken;
    logic        go_idle;
    logic        fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = accepted_ops;
      if (in_valid && in_ready) begin
        expected_views.push_back(deque_apply(in_data));
        taken = taken + 1;
      end
      accepted_ops <= taken;
      go_idle = (taken < QUIET_FROM || taken >= QUIET_TO) &&
                ($urandom_range(99) < IDLE_PCT);
      // hold off once until the deque has answered everything
      fire = (op_backlog.size() != 0) && !go_idle &&
             !(taken == PAUSE_AT && expected_views.size() != 0);
      if (!in_valid || in_ready) begin
        if (fire) begin
          in_valid <= 1'b1;
          in_data  <= op_backlog[0];
          op_backlog.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("result beat with no pending operation");
          mismatches++;
        end else begin
          compare_view(expected_views[0], out_data);
          expected_views.delete(0);
        end
      end
      if (accepted_ops >= QUIET_FROM && accepted_ops < QUIET_TO)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned goal;
    int          mode;
    int          run_len;
    int          pick;
    // empty deque, underflow on both ends, extremes, unused codes
    queue_op(FUNC_QUERY, 32'h0);
    queue_op(FUNC_POP_FRONT, 32'h1234_5678);
    queue_op(FUNC_POP_REAR, 32'hffff_ffff);
    queue_op(FUNC_PUSH_FRONT, 32'h7fff_ffff);
    queue_op(FUNC_PUSH_REAR, 32'h8000_0000);
    queue_op(FUNC_QUERY, 32'h0);
    queue_op(FUNC_POP_FRONT, 32'h0);
    queue_op(FUNC_POP_REAR, 32'h0);
    queue_op(FUNC_PUSH_REAR, 32'hffff_ffff);
    queue_op(FUNC_PUSH_FRONT, 32'h0);
    queue_op(FUNC_PUSH_FRONT, 32'h5555_5555);
    queue_op(FUNC_PUSH_REAR, 32'haaaa_aaaa);
    queue_op(3'd5, 32'h0);
    queue_op(3'd6, 32'h0);
    queue_op(3'd7, 32'h0);
    queue_op(FUNC_POP_REAR, 32'h0);
    queue_op(FUNC_POP_FRONT, 32'h0);
    queue_op(FUNC_POP_FRONT, 32'h0);
    queue_op(FUNC_POP_REAR, 32'h0);
    queue_op(FUNC_POP_FRONT, 32'h0);

    // random runs that fill, drain or churn the deque
    goal = op_backlog.size() + RANDOM_OPS;
    while (op_backlog.size() < goal) begin
      mode    = $urandom_range(2);
      run_len = $urandom_range(50, 10);
      repeat (run_len) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          queue_op(FUNC_W'(FUNC_QUERY + $urandom_range(3)), pick_value());
        end else if ((mode == 0 && pick < 80) || (mode == 1 && pick < 23) ||
                     (mode == 2 && pick < 54)) begin
          queue_op($urandom_range(1) ? FUNC_PUSH_REAR : FUNC_PUSH_FRONT, pick_value());
        end else begin
          queue_op($urandom_range(1) ? FUNC_POP_REAR : FUNC_POP_FRONT, pick_value());
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("double_ended_queue: match");
    else
      $display("double_ended_queue: mismatch");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("double_ended_queue: mismatch");
    $finish;
  end

endmodule
